// ===== hw/rtl/pdsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdsm_pkg;

  localparam logic [7:0] FREE_KEY   = 8'hFF;
  localparam int         SLOT_IDX_W = 8;

  typedef enum logic [1:0] {
    CMD_GET  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_NEXT = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pin_key;
    logic [7:0] new_state;
    logic [4:0] start_index;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] state_out;
    logic [7:0] found_key;
    logic [4:0] next_index;
  } out_item_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    cmd_t                  cmd;
    logic [7:0]            key;
    logic [7:0]            nstate;
    logic [4:0]            start;
    logic                  found;
    logic [7:0]            st;
    logic [7:0]            fkey;
    logic [4:0]            nidx;
    logic                  have_free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } probe_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [7:0]            key;
    logic [7:0]            state;
  } wb_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pdsm_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pdsm_in_if import pdsm_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdsm_out_if import pdsm_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pdsm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdsm_cell import pdsm_pkg::*; #(
  parameter logic [SLOT_IDX_W-1:0] CELL_IDX = 8'd0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] highz,
  input  wire wb_t        wb,
  input  wire probe_t     probe_in,
  output probe_t          probe_out
);

  logic [7:0] key_r, key_nxt;
  logic [7:0] state_r, state_nxt;
  probe_t     probe_r, probe_nxt;

  always_comb begin
    probe_nxt = probe_in;
    key_nxt   = key_r;
    state_nxt = state_r;
    if (probe_in.valid && !probe_in.found) begin
      case (probe_in.cmd)
        CMD_GET: begin
          if (key_r != FREE_KEY && key_r == probe_in.key) begin
            probe_nxt.found = 1'b1;
            probe_nxt.st    = state_r;
          end
        end
        CMD_SET: begin
          if (key_r == FREE_KEY) begin
            if (!probe_in.have_free) begin
              probe_nxt.have_free = 1'b1;
              probe_nxt.free_idx  = CELL_IDX;
            end
          end else if (key_r == probe_in.key) begin
            probe_nxt.found = 1'b1;
            if (probe_in.nstate == highz) begin
              key_nxt = FREE_KEY;
            end else begin
              state_nxt = probe_in.nstate;
            end
          end
        end
        CMD_NEXT: begin
          if (key_r != FREE_KEY && CELL_IDX >= {3'd0, probe_in.start}) begin
            probe_nxt.found = 1'b1;
            probe_nxt.fkey  = key_r;
            probe_nxt.st    = state_r;
            probe_nxt.nidx  = 5'(CELL_IDX + 8'd1);
          end
        end
        default: ;
      endcase
    end
    if (wb.en && wb.idx == CELL_IDX) begin
      key_nxt   = wb.key;
      state_nxt = wb.state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r         <= FREE_KEY;
      probe_r.valid <= 1'b0;
    end else begin
      key_r   <= key_nxt;
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign probe_out = probe_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pin_default_state_map_core.sv =====
// The token for an accepted item walks the slot chain one cell per cycle; at
// the chain's end the result is registered and any set's write-back is made,
// then the result waits for the output register to be free. The input is not
// ready again until the result has moved into the output register.
// Reset: synchronous, active low; all slots freed, high-impedance code 0.
// Slot states are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module pin_default_state_map_core import pdsm_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  pdsm_in_if.sink         in_if,
  pdsm_out_if.source      out_if
);

  fsm_t       state_r, state_nxt;
  logic [7:0] highz_r;
  out_item_t  res_r, res_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       out_valid_r, out_valid_nxt;
  wb_t        wb;
  probe_t     chain [TABLE_SLOTS+1];
  probe_t     tail;
  logic       accept;

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign tail        = chain[TABLE_SLOTS];

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = accept;
    chain[0].cmd       = cmd_t'(in_if.data.cmd);
    chain[0].key       = in_if.data.pin_key;
    chain[0].nstate    = in_if.data.new_state;
    chain[0].start     = in_if.data.start_index;
  end

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    pdsm_cell #(
      .CELL_IDX(SLOT_IDX_W'(g))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .highz     (highz_r),
      .wb        (wb),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    wb            = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (tail.valid) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (tail.cmd)
            CMD_GET: begin
              res_nxt.state_out = tail.found ? tail.st : highz_r;
            end
            CMD_SET: begin
              if (!tail.found) begin
                if (tail.have_free) begin
                  wb.en    = 1'b1;
                  wb.idx   = tail.free_idx;
                  wb.key   = tail.key;
                  wb.state = tail.nstate;
                end else begin
                  res_nxt.status = 1'b1;
                end
              end
            end
            CMD_NEXT: begin
              if (tail.found) begin
                res_nxt.state_out  = tail.st;
                res_nxt.found_key  = tail.fkey;
                res_nxt.next_index = tail.nidx;
              end else begin
                res_nxt.found_key  = FREE_KEY;
                res_nxt.next_index = tail.start;
              end
            end
            default: begin
              res_nxt.found_key = FREE_KEY;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      highz_r     <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) highz_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

endmodule

`default_nettype wire

// ===== sim/pin_default_state_map_core_checker.sv =====
`timescale 1ns / 1ps

module pin_default_state_map_core_checker import pdsm_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  pdsm_in_if         in_ch,
  pdsm_out_if        out_ch,
  output int         fail_count,
  output int         results_owed
);

  logic [7:0] pin_of_slot   [TABLE_SLOTS];
  logic [7:0] state_of_slot [TABLE_SLOTS];
  logic [7:0] highz_code;
  out_item_t  owed_results  [$];

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  // updates the table as the block would and returns the answer for one item
  function automatic out_item_t apply_pin_command(input in_item_t it);
    out_item_t r;
    bit        have_free;
    bit        matched;
    int        free_slot;
    r = '0;
    have_free = 1'b0;
    matched = 1'b0;
    free_slot = 0;
    case (cmd_t'(it.cmd))
      CMD_GET: begin
        r.state_out = highz_code;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (pin_of_slot[i] != FREE_KEY && pin_of_slot[i] == it.pin_key) begin
            r.state_out = state_of_slot[i];
            break;
          end
        end
      end
      CMD_SET: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (pin_of_slot[i] == FREE_KEY) begin
            if (!have_free) begin
              have_free = 1'b1;
              free_slot = i;
            end
          end else if (pin_of_slot[i] == it.pin_key) begin
            if (it.new_state == highz_code)
              pin_of_slot[i] = FREE_KEY;
            else
              state_of_slot[i] = it.new_state;
            matched = 1'b1;
            break;
          end
        end
        if (!matched) begin
          if (have_free) begin
            pin_of_slot[free_slot] = it.pin_key;
            state_of_slot[free_slot] = it.new_state;
          end else begin
            r.status = 1'b1;
          end
        end
      end
      CMD_NEXT: begin
        r.found_key = FREE_KEY;
        r.next_index = it.start_index;
        for (int i = int'(it.start_index); i < TABLE_SLOTS; i++) begin
          if (pin_of_slot[i] != FREE_KEY) begin
            r.found_key = pin_of_slot[i];
            r.state_out = state_of_slot[i];
            r.next_index = 5'(i + 1);
            break;
          end
        end
      end
      default: r.found_key = FREE_KEY;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      foreach (pin_of_slot[i]) begin
        pin_of_slot[i] = FREE_KEY;
        state_of_slot[i] = '0;
      end
      highz_code = '0;
      owed_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en)
        highz_code = cfg_wr_data;
      // results leave before this edge's item is logged
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("item out with none owed: %0d/%0d/%0d/%0d",
                                    got.status, got.state_out, got.found_key,
                                    got.next_index));
        end else begin
          want = owed_results.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.state_out != want.state_out)
            report_mismatch($sformatf("state_out got %0d want %0d",
                                      got.state_out, want.state_out));
          if (got.found_key != want.found_key)
            report_mismatch($sformatf("found_key got %0d want %0d",
                                      got.found_key, want.found_key));
          if (got.next_index != want.next_index)
            report_mismatch($sformatf("next_index got %0d want %0d",
                                      got.next_index, want.next_index));
        end
      end
      if (in_ch.valid && in_ch.ready)
        owed_results.push_back(apply_pin_command(in_ch.data));
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== sim/pin_default_state_map_core_test.sv =====
`timescale 1ns / 1ps

module pin_default_state_map_core_test;
  import pdsm_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 245;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  int         fail_count;
  int         results_owed;
  int         sent = 0;
  int         fill_base = 0;
  int         sender_idle_pct = 10;
  int         receiver_stall_pct = 10;
  bit         quiet = 1'b0;
  bit         long_hold_req = 1'b0;
  logic [7:0] highz_now = '0;

  pdsm_in_if  in_ch ();
  pdsm_out_if out_ch ();

  pin_default_state_map_core #(.TABLE_SLOTS(TABLE_SLOTS)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  pin_default_state_map_core_checker #(.TABLE_SLOTS(TABLE_SLOTS)) map_watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("pin_default_state_map_core_test: done, errors");
    $finish;
  end

  // result side: ready bursts, random stalls and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < receiver_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] pick_state();
    if ($urandom_range(0, 4) == 0)
      return highz_now;
    return 8'($urandom);
  endfunction

  task automatic offer_pin_command(input cmd_t c, input logic [7:0] key,
                                   input logic [7:0] st, input logic [4:0] start);
    in_item_t it;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    it = '{cmd: c, pin_key: key, new_state: st, start_index: start};
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_highz(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    highz_now = v;
  endtask

  task automatic offer_pool_item(input int base, input int span);
    offer_pin_command(cmd_t'($urandom_range(0, 2)), 8'(base + $urandom_range(0, span - 1)),
                      pick_state(), 5'($urandom_range(0, TABLE_SLOTS)));
  endtask

  task automatic run_pin_phase(input int n_items, input int span);
    int stop_at;
    int kind;
    int base;
    stop_at = sent + n_items;
    base = $urandom_range(0, 255 - span);
    while (sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        repeat (6) offer_pool_item(base, span);
      end else if (kind == 5) begin
        // fresh pins until the table is full, then a free-key set on a full table
        fill_base = $urandom_range(0, 254 - TABLE_SLOTS - 2);
        for (int j = 0; j < TABLE_SLOTS + 2; j++)
          offer_pin_command(CMD_SET, 8'(fill_base + j), pick_state(), 5'($urandom));
        offer_pin_command(CMD_SET, FREE_KEY, pick_state(), 5'($urandom));
      end else if (kind == 6) begin
        for (int j = 0; j <= TABLE_SLOTS + 1; j++)
          offer_pin_command(CMD_NEXT, 8'($urandom), 8'($urandom), 5'(j));
      end else if (kind == 7) begin
        for (int j = 0; j < span; j++)
          offer_pin_command(CMD_SET, 8'(base + j), highz_now, 5'($urandom));
        for (int j = 0; j < TABLE_SLOTS + 2; j++)
          offer_pin_command(CMD_SET, 8'(fill_base + j), highz_now, 5'($urandom));
      end else begin
        repeat (4)
          offer_pin_command(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                            5'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] phase_highz [PHASES];
    int         phase_span  [PHASES];
    phase_highz = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFE, 8'h00};
    phase_span  = '{4, 24, 12, 40, 8, 24, 16};
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, high-impedance code at its reset value
    offer_pin_command(CMD_GET, 8'd0, 8'd0, 5'd0);
    offer_pin_command(CMD_GET, FREE_KEY, 8'd0, 5'd0);
    offer_pin_command(CMD_NEXT, 8'd0, 8'd0, 5'd0);
    offer_pin_command(CMD_SET, 8'd0, 8'h80, 5'd0);
    offer_pin_command(CMD_SET, 8'd254, 8'hFF, 5'd0);
    offer_pin_command(CMD_SET, FREE_KEY, 8'h33, 5'd0);
    offer_pin_command(CMD_GET, 8'd0, 8'd0, 5'd0);
    offer_pin_command(CMD_GET, 8'd254, 8'd0, 5'd0);
    offer_pin_command(CMD_SET, 8'd0, 8'h7F, 5'd0);
    offer_pin_command(CMD_GET, 8'd0, 8'd0, 5'd0);
    offer_pin_command(CMD_NEXT, 8'd0, 8'd0, 5'd0);
    offer_pin_command(CMD_NEXT, 8'd0, 8'd0, 5'd1);
    offer_pin_command(CMD_NEXT, 8'd0, 8'd0, 5'd2);
    offer_pin_command(CMD_NEXT, 8'd0, 8'd0, 5'd16);
    offer_pin_command(CMD_NEXT, 8'd0, 8'd0, 5'd31);
    offer_pin_command(CMD_SET, 8'd254, 8'd0, 5'd0);
    offer_pin_command(CMD_GET, 8'd254, 8'd0, 5'd0);
    offer_pin_command(CMD_SET, 8'd10, 8'd0, 5'd0);
    offer_pin_command(CMD_GET, 8'd10, 8'd0, 5'd0);
    offer_pin_command(CMD_NONE, 8'hAA, 8'h55, 5'h1F);
    offer_pin_command(CMD_GET, FREE_KEY, 8'hFF, 5'h1F);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_highz((p == 1 || p == 4) ? 8'($urandom) : phase_highz[p]);
      if (p == PHASES - 1) begin
        quiet = 1'b1;
        sender_idle_pct = 0;
      end else begin
        sender_idle_pct = 12 * $urandom_range(0, 2);
        receiver_stall_pct = 12 * $urandom_range(0, 2);
      end
      if (p == 1) begin
        // output held off while items keep coming
        long_hold_req = 1'b1;
        sender_idle_pct = 0;
        repeat (24) offer_pool_item(0, 32);
        sender_idle_pct = 12;
      end
      run_pin_phase(PHASE_ITEMS, phase_span[p]);
    end

    drain_results();
    repeat (TABLE_SLOTS + 4) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("pin_default_state_map_core_test: done, clean");
    else
      $display("pin_default_state_map_core_test: done, errors");
    $finish;
  end

endmodule
